>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define QDD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define QDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/qdd_pkg.sv
// Types and constants of the debounced quadrature decoder.
`default_nettype none

package qdd_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DEBOUNCE_W = 16;
  localparam int unsigned OUT_CNT_W  = 8;
  localparam int unsigned PHASE_W    = 2;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd5;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } qdd_dir_e;

  // Indexed by {new B, new A, old B, old A}, all as inverted pin levels.
  localparam qdd_dir_e DIR_TABLE [16] = '{
    DIR_NONE, DIR_UP,   DIR_DOWN, DIR_NONE,
    DIR_DOWN, DIR_NONE, DIR_NONE, DIR_UP,
    DIR_UP,   DIR_NONE, DIR_NONE, DIR_DOWN,
    DIR_NONE, DIR_DOWN, DIR_UP,   DIR_NONE
  };

  typedef struct packed {
    qdd_dir_e             dir;
    logic [PHASE_W-1:0]   next_phase;
  } qdd_step_t;

endpackage

`default_nettype wire

>>> rtl/core/qdd_if.sv
// Handshake interfaces for the event channel and the result channel.
`default_nettype none

interface qdd_evt_if import qdd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic              phase_a;
  logic              phase_b;
  logic [TIME_W-1:0] time_ms;

  modport source (output valid, op, phase_a, phase_b, time_ms, input ready);
  modport sink   (input valid, op, phase_a, phase_b, time_ms, output ready);
endinterface

interface qdd_res_if import qdd_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_CNT_W-1:0] count_value;
  logic                        accepted;

  modport source (output valid, count_value, accepted, input ready);
  modport sink   (input valid, count_value, accepted, output ready);
endinterface

`default_nettype wire

>>> rtl/core/qdd_step_decode.sv
// Quadrature transition decoder: direction and new phase from old and raw pins.
`default_nettype none

module qdd_step_decode import qdd_pkg::*; (
  input  logic [PHASE_W-1:0] prev_phase_i,
  input  logic               phase_a_i,
  input  logic               phase_b_i,
  output qdd_step_t          step_o
);

  logic [PHASE_W-1:0] new_phase;
  logic [3:0]         trans_idx;

  // Pins are active low, so the decoded phase is the inverted level.
  assign new_phase = {~phase_b_i, ~phase_a_i};
  assign trans_idx = {new_phase, prev_phase_i};

  assign step_o.dir        = DIR_TABLE[trans_idx];
  assign step_o.next_phase = new_phase;

endmodule

`default_nettype wire

>>> rtl/core/quadrature_decoder_debounced_unit.sv
// Debounced quadrature decoder: one event or read item in, one result item out.
//
// Items arrive on evt_i. With op at edge, the item carries the raw active-low
// levels of pins A and B and a millisecond timestamp; it counts only when the
// wrapping time since the last counted edge is strictly above debounce_ms.
// A counted edge moves the step counter by one step up or down (double steps
// are dropped but still update phase and timestamp). With op at read, the
// result returns the counter and the counter clears.
// Each item yields exactly one result item on res_o. An item goes into an
// input register and its result is computed from there into the result
// register, so a result is offered from the result register, and one item
// per cycle is sustained as long as res_o is taken.
// If the receiver stalls, the result register holds and the input register
// still takes one more item; after that evt_i.ready drops until res_o drains.
// debounce_ms is written through debounce_we_i/debounce_wdata_i, by the user
// only while idle; the block does not enforce it. Reset clears the counter,
// stored phase and timestamp, sets debounce_ms to 5 and empties both registers.
`default_nettype none
`include "assert_macros.svh"

module quadrature_decoder_debounced_unit import qdd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  debounce_we_i,
  input  logic [DEBOUNCE_W-1:0] debounce_wdata_i,
  qdd_evt_if.sink               evt_i,
  qdd_res_if.source             res_o
);

  localparam int unsigned ExtW = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

  logic [DEBOUNCE_W-1:0]  debounce_q;

  // Input register.
  logic                   in_valid_q;
  logic                   in_op_q;
  logic                   in_a_q;
  logic                   in_b_q;
  logic [TIME_W-1:0]      in_time_q;

  // Decoder state.
  logic [TIME_W-1:0]      last_time_q,  last_time_d;
  logic [PHASE_W-1:0]     prev_phase_q, prev_phase_d;
  logic [COUNT_WIDTH-1:0] count_q,      count_d;

  // Result register.
  logic                   out_valid_q;
  logic [OUT_CNT_W-1:0]   out_count_q,  out_count_d;
  logic                   out_acc_q,    out_acc_d;

  logic                   evt_fire;
  logic                   advance;
  logic                   proc_fire;
  logic [TIME_W-1:0]      elapsed;
  logic                   debounce_pass;
  logic [ExtW-1:0]        count_ext;
  qdd_step_t              step;

  assign advance     = !out_valid_q || res_o.ready;
  assign proc_fire   = in_valid_q && advance;
  assign evt_i.ready = !in_valid_q || advance;
  assign evt_fire    = evt_i.valid && evt_i.ready;

  assign res_o.valid       = out_valid_q;
  assign res_o.count_value = out_count_q;
  assign res_o.accepted    = out_acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
    end else if (debounce_we_i) begin
      debounce_q <= debounce_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (evt_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_fire) begin
      in_op_q   <= evt_i.op;
      in_a_q    <= evt_i.phase_a;
      in_b_q    <= evt_i.phase_b;
      in_time_q <= evt_i.time_ms;
    end
  end

  qdd_step_decode u_step_decode (
    .prev_phase_i (prev_phase_q),
    .phase_a_i    (in_a_q),
    .phase_b_i    (in_b_q),
    .step_o       (step)
  );

  assign elapsed       = in_time_q - last_time_q;
  assign debounce_pass = elapsed > TIME_W'(debounce_q);
  assign count_ext     = ExtW'(count_q);

  always_comb begin
    last_time_d  = last_time_q;
    prev_phase_d = prev_phase_q;
    count_d      = count_q;
    out_count_d  = '0;
    out_acc_d    = 1'b0;
    if (in_op_q == OP_READ) begin
      out_count_d = count_ext[OUT_CNT_W-1:0];
      count_d     = '0;
    end else if (debounce_pass) begin
      last_time_d  = in_time_q;
      prev_phase_d = step.next_phase;
      out_acc_d    = 1'b1;
      case (step.dir)
        DIR_UP:   count_d = count_q + COUNT_WIDTH'(1);
        DIR_DOWN: count_d = count_q - COUNT_WIDTH'(1);
        default:  count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q  <= '0;
      prev_phase_q <= '0;
      count_q      <= '0;
    end else if (proc_fire) begin
      last_time_q  <= last_time_d;
      prev_phase_q <= prev_phase_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      out_count_q <= out_count_d;
      out_acc_q   <= out_acc_d;
    end
  end

  // A counted edge never reports a count; a read never reports a counted edge.
  `QDD_ASSERT_NOW(a_acc_no_count, clk_i, rst_ni,
                  res_o.valid && res_o.accepted, res_o.count_value == '0)

  // A read leaves the counter at zero.
  `QDD_ASSERT_NEXT(a_read_clears, clk_i, rst_ni,
                   proc_fire && (in_op_q == OP_READ), count_q == '0)

  // A rejected edge leaves timestamp, phase and counter untouched.
  `QDD_ASSERT_NEXT(a_reject_holds, clk_i, rst_ni,
                   proc_fire && (in_op_q == OP_EDGE) && !debounce_pass,
                   $stable(last_time_q) && $stable(prev_phase_q) && $stable(count_q))

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the debounced quadrature decoder unit.
`default_nettype none

module tb import qdd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CNT_W = 8;
  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned ITEMS_PER_PHASE = 155;

  typedef struct {
    logic signed [OUT_CNT_W-1:0] count_value;
    logic                        accepted;
  } qdd_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_PATTERN,
    STALL_SPARSE,
    STALL_LONG
  } stall_style_e;

  typedef enum int {
    SEG_SPIN,
    SEG_NOISE
  } segment_e;

  // Phase value that follows p when the shaft turns one step up.
  function automatic logic [PHASE_W-1:0] up_next(input logic [PHASE_W-1:0] p);
    case (p)
      2'd0:    up_next = 2'd2;
      2'd2:    up_next = 2'd3;
      2'd3:    up_next = 2'd1;
      default: up_next = 2'd0;
    endcase
  endfunction

  class qdd_scoreboard;
    logic [DEBOUNCE_W-1:0] debounce;
    logic [TIME_W-1:0]     last_time;
    logic [PHASE_W-1:0]    prev_phase;
    logic [CNT_W-1:0]      steps;
    qdd_result_t           expected_q[$];
    int                    errors;

    function new();
      debounce   = DEBOUNCE_RESET;
      last_time  = '0;
      prev_phase = '0;
      steps      = '0;
      errors     = 0;
    endfunction

    function void set_debounce(input logic [DEBOUNCE_W-1:0] value);
      debounce = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Predicts the result of one accepted item and updates the decoder state.
    function void note_item(input logic op, input logic a, input logic b,
                            input logic [TIME_W-1:0] t);
      qdd_result_t        r;
      logic [PHASE_W-1:0] next_phase;
      logic [TIME_W-1:0]  elapsed;
      qdd_dir_e           dir;
      r.count_value = '0;
      r.accepted    = 1'b0;
      if (op == OP_READ) begin
        r.count_value = steps[OUT_CNT_W-1:0];
        steps = '0;
      end else begin
        elapsed = t - last_time;
        if (elapsed > TIME_W'(debounce)) begin
          // Pins are active low, so the stored phase holds the inverted levels.
          next_phase = {~b, ~a};
          if (next_phase == up_next(prev_phase)) dir = DIR_UP;
          else if (prev_phase == up_next(next_phase)) dir = DIR_DOWN;
          else dir = DIR_NONE;
          if (dir == DIR_UP) steps = steps + 1'b1;
          else if (dir == DIR_DOWN) steps = steps - 1'b1;
          last_time  = t;
          prev_phase = next_phase;
          r.accepted = 1'b1;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(input logic signed [OUT_CNT_W-1:0] count_value,
                               input logic accepted);
      qdd_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: count_value %0d, accepted %0b", count_value, accepted);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (count_value !== e.count_value) begin
          $error("count_value: expected %0d, got %0d", e.count_value, count_value);
          errors++;
        end
        if (accepted !== e.accepted) begin
          $error("accepted: expected %0b, got %0b", e.accepted, accepted);
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  debounce_we_i;
  logic [DEBOUNCE_W-1:0] debounce_wdata_i;
  int unsigned           cycles;
  int                    burst_left;
  qdd_scoreboard         sb;

  qdd_evt_if evt ();
  qdd_res_if res ();

  quadrature_decoder_debounced_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .debounce_we_i   (debounce_we_i),
    .debounce_wdata_i(debounce_wdata_i),
    .evt_i           (evt),
    .res_o           (res)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) sb.check_result(res.count_value, res.accepted);
  end

  // Result side: stretches of steady taking alternate with stall patterns.
  initial begin
    int           len;
    stall_style_e style;
    logic [31:0]  pattern;
    res.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      len     = $urandom_range(8, 64);
      style   = stall_style_e'($urandom_range(0, 3));
      pattern = $urandom;
      for (int k = 0; k < len; k++) begin
        @(posedge clk_i);
        case (style)
          STALL_NONE:    res.ready <= 1'b1;
          STALL_PATTERN: res.ready <= pattern[k % 32];
          STALL_SPARSE:  res.ready <= ($urandom_range(0, 3) != 0);
          default:       res.ready <= (k >= len / 2);
        endcase
      end
    end
  end

  task automatic send_item(input logic op, input logic a, input logic b,
                           input logic [TIME_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        evt.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    evt.valid   <= 1'b1;
    evt.op      <= op;
    evt.phase_a <= a;
    evt.phase_b <= b;
    evt.time_ms <= t;
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
    sb.note_item(op, a, b, t);
  endtask

  task automatic drain();
    evt.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_debounce(input logic [DEBOUNCE_W-1:0] value);
    debounce_we_i    <= 1'b1;
    debounce_wdata_i <= value;
    @(posedge clk_i);
    debounce_we_i <= 1'b0;
    sb.set_debounce(value);
  endtask

  // Timestamp that clears the debounce window, mostly right at its edge.
  function automatic logic [TIME_W-1:0] passing_time();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return sb.last_time + sb.debounce + 1 + $urandom_range(0, 2);
    if (pick < 9) return sb.last_time + sb.debounce + 1 + $urandom_range(0, 5000);
    return sb.last_time + sb.debounce + 1 + $urandom_range(0, 32'h7fff_ffff);
  endfunction

  function automatic logic [TIME_W-1:0] bouncing_time();
    if ($urandom_range(0, 1) == 0) return sb.last_time + sb.debounce;
    return sb.last_time + $urandom_range(0, sb.debounce);
  endfunction

  task automatic send_noise();
    logic [TIME_W-1:0] t;
    case ($urandom_range(0, 2))
      0:       t = $urandom;
      1:       t = passing_time();
      default: t = bouncing_time();
    endcase
    send_item(($urandom_range(0, 4) == 0) ? OP_READ : OP_EDGE,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), t);
  endtask

  // Mostly clean rotation in one direction, with some bounce, skips and reads.
  task automatic send_spin_item(input bit upward);
    logic [PHASE_W-1:0] p;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      send_item(OP_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
    end else if (pick < 8) begin
      p = PHASE_W'($urandom_range(0, 3));
      send_item(OP_EDGE, ~p[0], ~p[1], bouncing_time());
    end else if (pick < 11) begin
      p = sb.prev_phase ^ 2'b11;
      send_item(OP_EDGE, ~p[0], ~p[1], passing_time());
    end else begin
      p = upward ? up_next(sb.prev_phase) : up_next(up_next(up_next(sb.prev_phase)));
      send_item(OP_EDGE, ~p[0], ~p[1], passing_time());
    end
  endtask

  task automatic run_random(input int count);
    int       remaining;
    int       len;
    bit       upward;
    segment_e seg;
    remaining = count;
    while (remaining > 0) begin
      seg = ($urandom_range(0, 9) < 7) ? SEG_SPIN : SEG_NOISE;
      if (seg == SEG_SPIN) len = $urandom_range(4, 250);
      else len = $urandom_range(2, 20);
      if (len > remaining) len = remaining;
      upward = 1'($urandom_range(0, 1));
      for (int k = 0; k < len; k++) begin
        if (seg == SEG_SPIN) send_spin_item(upward);
        else send_noise();
      end
      remaining -= len;
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    burst_left = 0;
    rst_ni <= 1'b0;
    debounce_we_i <= 1'b0;
    debounce_wdata_i <= '0;
    evt.valid <= 1'b0;
    evt.op <= OP_EDGE;
    evt.phase_a <= 1'b0;
    evt.phase_b <= 1'b0;
    evt.time_ms <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset debounce value of 5.
    send_item(OP_READ, 1'b1, 1'b1, 32'hffff_ffff);
    send_item(OP_EDGE, 1'b0, 1'b0, 32'd5);          // exactly at the window: rejected
    send_item(OP_EDGE, 1'b0, 1'b0, 32'd6);          // double step from rest
    send_item(OP_EDGE, 1'b1, 1'b0, 32'hffff_ffff);  // one step down
    send_item(OP_EDGE, 1'b1, 1'b1, 32'd3);          // wraps to within the window
    send_item(OP_EDGE, 1'b1, 1'b1, 32'd5);          // wraps past the window
    send_item(OP_READ, 1'b0, 1'b0, 32'd0);
    send_item(OP_READ, 1'b1, 1'b0, 32'd0);
    send_item(OP_EDGE, 1'b1, 1'b0, 32'd12);         // one step up
    send_item(OP_EDGE, 1'b0, 1'b0, 32'd18);
    send_item(OP_EDGE, 1'b0, 1'b1, 32'd24);
    send_item(OP_EDGE, 1'b1, 1'b1, 32'd30);
    send_item(OP_EDGE, 1'b0, 1'b0, 32'd31);         // bounce
    send_item(OP_EDGE, 1'b0, 1'b0, 32'd36);         // double step
    send_item(OP_READ, 1'b0, 1'b1, 32'h8000_0000);
    drain();

    write_debounce('0);
    send_item(OP_EDGE, 1'b1, 1'b0, sb.last_time);      // zero elapsed: rejected
    send_item(OP_EDGE, 1'b1, 1'b0, sb.last_time + 1);
    run_random(ITEMS_PER_PHASE);
    drain();

    write_debounce(16'hffff);
    send_item(OP_EDGE, 1'b0, 1'b1, sb.last_time + 32'hffff);
    send_item(OP_EDGE, 1'b0, 1'b1, sb.last_time + 32'h1_0000);
    run_random(ITEMS_PER_PHASE);
    drain();

    write_debounce(16'd1);
    run_random(ITEMS_PER_PHASE);
    drain();

    write_debounce(16'($urandom_range(2, 200)));
    run_random(ITEMS_PER_PHASE);
    drain();

    write_debounce(16'h8000 | 16'($urandom_range(0, 16'h7fff)));
    run_random(ITEMS_PER_PHASE);
    drain();

    write_debounce(DEBOUNCE_RESET);
    run_random(ITEMS_PER_PHASE);
    drain();

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
